[src/ofv_pkg.sv]
// Package for the order frame validator.
// Holds the request type, frame marker bytes and status codes.
// No dependencies.
package ofv_pkg;

  localparam int POS_W = 17;
  localparam int LEN_W = 16;

  localparam logic [7:0] MARK_A   = 8'h3E;
  localparam logic [7:0] MARK_B   = 8'h11;
  localparam logic [7:0] MARK_END = 8'hE3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_HEAD = 2'd1;
  localparam logic [1:0] ST_BAD_TAIL = 2'd2;
  localparam logic [1:0] ST_TRUNC    = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       region_first;
    logic       region_last;
  } ofv_req_t;

endpackage

[src/ofv_frame_check.sv]
// Frame checker state and per-byte step logic.
// Keeps frame position, payload length and first error; gives the region status.
// Depends on ofv_pkg.
module ofv_frame_check #(
  parameter int HEAD_BYTES    = 8,
  parameter int LENGTH_OFFSET = 2,
  parameter int TAIL_BYTES    = 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  take,
  input  ofv_pkg::ofv_req_t     req,
  output logic [1:0]            status
);
  import ofv_pkg::*;

  localparam logic [POS_W-1:0] LEN_HI_POS = POS_W'(LENGTH_OFFSET);
  localparam logic [POS_W-1:0] LEN_LO_POS = POS_W'(LENGTH_OFFSET + 1);
  localparam logic [POS_W-1:0] FRAME_EXTRA = POS_W'(HEAD_BYTES + TAIL_BYTES);

  logic [POS_W-1:0] frame_position, frame_position_next;
  logic [LEN_W-1:0] payload_length, payload_length_next;
  logic [1:0]       error_code, error_code_next;
  logic             error_seen, error_seen_next;

  logic [POS_W-1:0] pos0;
  logic [LEN_W-1:0] len0, len1;
  logic [1:0]       code0;
  logic             seen0;
  logic [POS_W-1:0] total;
  logic             head_bad, tail_bad;
  logic [POS_W-1:0] pos1;
  logic [LEN_W-1:0] len2;
  logic [1:0]       code1;
  logic             seen1;

  always_comb begin
    if (req.region_first) begin
      pos0  = '0;
      len0  = '0;
      code0 = ST_OK;
      seen0 = 1'b0;
    end else begin
      pos0  = frame_position;
      len0  = payload_length;
      code0 = error_code;
      seen0 = error_seen;
    end

    head_bad = ((pos0 == '0) && (req.data_byte != MARK_A)) ||
               ((pos0 == POS_W'(1)) && (req.data_byte != MARK_B));

    if (pos0 == LEN_HI_POS) begin
      len1 = {req.data_byte, 8'h00};
    end else if (pos0 == LEN_LO_POS) begin
      len1 = {len0[15:8], req.data_byte};
    end else begin
      len1 = len0;
    end

    total    = POS_W'(len1) + FRAME_EXTRA;
    tail_bad = ((pos0 == total - POS_W'(2)) && (req.data_byte != MARK_B)) ||
               ((pos0 == total - POS_W'(1)) && (req.data_byte != MARK_END));

    pos1  = pos0;
    len2  = len0;
    code1 = code0;
    seen1 = seen0;
    if (!seen0) begin
      if (head_bad) begin
        code1 = ST_BAD_HEAD;
        seen1 = 1'b1;
      end else if (tail_bad) begin
        len2  = len1;
        code1 = ST_BAD_TAIL;
        seen1 = 1'b1;
      end else begin
        len2 = len1;
        pos1 = (pos0 == total - POS_W'(1)) ? '0 : pos0 + POS_W'(1);
      end
    end

    if (seen1) begin
      status = code1;
    end else if (pos1 != '0) begin
      status = ST_TRUNC;
    end else begin
      status = ST_OK;
    end

    if (req.region_last) begin
      frame_position_next = '0;
      payload_length_next = '0;
      error_code_next     = ST_OK;
      error_seen_next     = 1'b0;
    end else begin
      frame_position_next = pos1;
      payload_length_next = len2;
      error_code_next     = code1;
      error_seen_next     = seen1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_position <= '0;
      payload_length <= '0;
      error_code     <= ST_OK;
      error_seen     <= 1'b0;
    end else if (take) begin
      frame_position <= frame_position_next;
      payload_length <= payload_length_next;
      error_code     <= error_code_next;
      error_seen     <= error_seen_next;
    end
  end

endmodule

[src/order_frame_validator.sv]
// Order frame validator top level: request register, frame checker, status register.
// The status register loads a region's status when its last byte is taken.
// Throughput: one byte per cycle; the input stalls only while a region's last byte
// waits behind a stalled status. Reset clears frame position, length, error state
// and both pipeline valids. Depends on ofv_pkg and ofv_frame_check.
module order_frame_validator #(
  parameter int HEAD_BYTES    = 8,
  parameter int LENGTH_OFFSET = 2,
  parameter int TAIL_BYTES    = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_stall,
  input  logic [7:0] data_byte,
  input  logic       region_first,
  input  logic       region_last,
  output logic       status_valid,
  input  logic       status_stall,
  output logic [1:0] check_status
);
  import ofv_pkg::*;

  ofv_req_t   req;
  logic       req_valid;
  logic       take;
  logic       load_status;
  logic [1:0] step_status;

  assign take        = req_valid && (!req.region_last || !status_valid || !status_stall);
  assign load_status = take && req.region_last;
  assign byte_stall  = req_valid && !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!byte_stall) begin
      req_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) begin
      req.data_byte    <= data_byte;
      req.region_first <= region_first;
      req.region_last  <= region_last;
    end
  end

  ofv_frame_check #(
    .HEAD_BYTES    (HEAD_BYTES),
    .LENGTH_OFFSET (LENGTH_OFFSET),
    .TAIL_BYTES    (TAIL_BYTES)
  ) u_check (
    .clk    (clk),
    .rst    (rst),
    .take   (take),
    .req    (req),
    .status (step_status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      status_valid <= 1'b0;
    end else if (load_status) begin
      status_valid <= 1'b1;
    end else if (!status_stall) begin
      status_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_status) begin
      check_status <= step_status;
    end
  end

endmodule

[tb/sv/order_frame_validator_tb.sv]
// Self-checking testbench for order_frame_validator: regions of order frames are streamed
// byte by byte, each region's status is predicted in a scoreboard class and checked in order.
// Depends on ofv_pkg and the order_frame_validator RTL.
module order_frame_validator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ofv_pkg::*;

  localparam int HEAD_BYTES    = 8;
  localparam int LENGTH_OFFSET = 2;
  localparam int TAIL_BYTES    = 2;

  localparam int RANDOM_BYTES = 2000;
  localparam int LONG_HOLD    = 200;
  localparam int DRAIN_CYCLES = 8;

  class frame_status_board;
    bit [POS_W-1:0] frame_pos;
    bit [LEN_W-1:0] pay_len;
    logic [1:0]     err_code;
    bit             err_seen;
    logic [1:0]     pending_status[$];
    int             mismatches;
    int             regions;
    int             bytes_seen;

    function void clear_frame();
      frame_pos = '0;
      pay_len   = '0;
      err_code  = ST_OK;
      err_seen  = 1'b0;
    endfunction

    function void flag_error(logic [1:0] code);
      err_code = code;
      err_seen = 1'b1;
    endfunction

    function void advance_frame(logic [7:0] b);
      int unsigned pos;
      int unsigned total;
      pos = 32'(frame_pos);
      if ((pos == 0 && b != MARK_A) || (pos == 1 && b != MARK_B)) begin
        flag_error(ST_BAD_HEAD);
        return;
      end
      if (pos == LENGTH_OFFSET)
        pay_len = {b, 8'h00};
      else if (pos == LENGTH_OFFSET + 1)
        pay_len = {pay_len[15:8], b};
      total = HEAD_BYTES + pay_len + TAIL_BYTES;
      if ((pos == total - 2 && b != MARK_B) || (pos == total - 1 && b != MARK_END)) begin
        flag_error(ST_BAD_TAIL);
        return;
      end
      if (pos == total - 1)
        frame_pos = '0;
      else
        frame_pos = POS_W'(pos + 1);
    endfunction

    // Accepted request: update the frame state, queue a status at region end.
    function void note_byte(ofv_req_t r);
      bytes_seen++;
      if (r.region_first)
        clear_frame();
      if (!err_seen)
        advance_frame(r.data_byte);
      if (r.region_last) begin
        if (err_seen)
          pending_status.push_back(err_code);
        else if (frame_pos != 0)
          pending_status.push_back(ST_TRUNC);
        else
          pending_status.push_back(ST_OK);
        regions++;
        clear_frame();
      end
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    task check_result(logic [1:0] got);
      logic [1:0] want;
      if (pending_status.size() == 0) begin
        report_mismatch($sformatf("status %0d with no region pending", got));
      end else begin
        want = pending_status.pop_front();
        if (got !== want)
          report_mismatch($sformatf("check_status %0d, expected %0d", got, want));
      end
    endtask

    function int pending();
      return pending_status.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       byte_valid = 1'b0;
  logic       byte_stall;
  logic [7:0] data_byte = 8'h00;
  logic       region_first = 1'b0;
  logic       region_last = 1'b0;
  logic       status_valid;
  logic       status_stall = 1'b0;
  logic [1:0] check_status;

  frame_status_board sb;
  logic [7:0]        bytes_q[$];
  bit                no_idle = 1'b0;
  bit                hold_req = 1'b0;
  int                random_sent = 0;

  order_frame_validator #(
    .HEAD_BYTES   (HEAD_BYTES),
    .LENGTH_OFFSET(LENGTH_OFFSET),
    .TAIL_BYTES   (TAIL_BYTES)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (byte_valid),
    .byte_stall  (byte_stall),
    .data_byte   (data_byte),
    .region_first(region_first),
    .region_last (region_last),
    .status_valid(status_valid),
    .status_stall(status_stall),
    .check_status(check_status)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    ofv_req_t r;
    if (!rst) begin
      if (byte_valid && !byte_stall) begin
        r.data_byte    = data_byte;
        r.region_first = region_first;
        r.region_last  = region_last;
        sb.note_byte(r);
      end
      if (status_valid && !status_stall)
        sb.check_result(check_status);
    end
  end

  function automatic int draw_gap();
    if (no_idle)
      return 0;
    if ($urandom_range(0, 1) == 0)
      return 0;
    return $urandom_range(1, 16);
  endfunction

  // Status receiver: random stall per status, long hold on request.
  initial begin
    int stall_left;
    bit took;
    stall_left = 0;
    forever begin
      @(posedge clk);
      took = status_valid && !status_stall;
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = LONG_HOLD;
      end else if (took) begin
        stall_left = draw_gap();
      end else if (stall_left > 0) begin
        stall_left--;
      end
      status_stall <= (stall_left != 0);
    end
  end

  task automatic send_byte(logic [7:0] d, logic first, logic last);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_valid   <= 1'b1;
    data_byte    <= d;
    region_first <= first;
    region_last  <= last;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
  endtask

  // Sends bytes_q as one region; restart_at > 0 raises region_first mid-region.
  task automatic send_region(bit with_first, int restart_at);
    int n;
    n = bytes_q.size();
    for (int i = 0; i < n; i++)
      send_byte(bytes_q[i], (i == 0 && with_first) || (i == restart_at), i == n - 1);
    bytes_q.delete();
  endtask

  function automatic void add_frame(int unsigned len);
    logic [15:0] l;
    logic [7:0]  b;
    l = 16'(len);
    for (int i = 0; i < HEAD_BYTES; i++) begin
      if (i == 0)
        b = MARK_A;
      else if (i == 1)
        b = MARK_B;
      else if (i == LENGTH_OFFSET)
        b = l[15:8];
      else if (i == LENGTH_OFFSET + 1)
        b = l[7:0];
      else
        b = 8'($urandom);
      bytes_q.push_back(b);
    end
    for (int i = 0; i < l; i++) begin
      b = 8'($urandom);
      bytes_q.push_back(b);
    end
    for (int i = 0; i < TAIL_BYTES - 2; i++) begin
      b = 8'($urandom);
      bytes_q.push_back(b);
    end
    bytes_q.push_back(MARK_B);
    bytes_q.push_back(MARK_END);
  endfunction

  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6)
      return $urandom_range(0, 6);
    if (r < 9)
      return $urandom_range(7, 40);
    return $urandom_range(41, 300);
  endfunction

  task automatic send_random_region();
    int unsigned kind;
    int          restart_at;
    int          n;
    logic [7:0]  b;
    kind       = $urandom_range(0, 99);
    restart_at = -1;
    repeat ($urandom_range(1, 3)) add_frame(pick_len());
    n = bytes_q.size();
    if (kind < 45) begin
      // well-formed
    end else if (kind < 62) begin
      b = 8'($urandom);
      bytes_q[$urandom_range(0, n - 1)] = b;
    end else if (kind < 72) begin
      repeat ($urandom_range(1, (n - 1 < 12) ? n - 1 : 12)) void'(bytes_q.pop_back());
    end else if (kind < 80) begin
      if ($urandom_range(0, 1))
        bytes_q.push_back(MARK_A);
      repeat ($urandom_range(1, 12)) begin
        b = 8'($urandom);
        bytes_q.push_back(b);
      end
    end else if (kind < 88) begin
      bytes_q.delete();
      repeat ($urandom_range(1, 12)) begin
        b = 8'($urandom);
        bytes_q.push_back(b);
      end
    end else begin
      restart_at = $urandom_range(1, n - 1);
    end
    random_sent += bytes_q.size();
    send_region($urandom_range(0, 4) != 0, restart_at);
  endtask

  task automatic drain();
    byte_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int         rn;
    logic [7:0] v;
    sb = new();
    sb.clear_frame();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: region before any region_first, empty payload
    add_frame(0);
    send_region(1'b0, -1);
    // region ends after the first head byte
    bytes_q.push_back(MARK_A);
    send_region(1'b1, -1);
    // bad first head byte
    bytes_q.push_back(8'hFF);
    send_region(1'b1, -1);
    // bad second head byte
    bytes_q.push_back(MARK_A);
    bytes_q.push_back(8'h00);
    send_region(1'b1, -1);
    // bad final tail byte
    add_frame(0);
    bytes_q[bytes_q.size() - 1] = 8'h00;
    send_region(1'b1, -1);
    drain();

    rn = 0;
    while (random_sent < RANDOM_BYTES) begin
      no_idle = ($urandom_range(0, 6) == 0);
      if (rn == 8) begin
        // output held off while single-byte regions keep arriving
        no_idle  = 1'b1;
        hold_req = 1'b1;
        while (hold_req) @(posedge clk);
        repeat (30) begin
          v = 8'($urandom);
          bytes_q.push_back($urandom_range(0, 1) ? MARK_A : v);
          random_sent += 1;
          send_region(1'b1, -1);
        end
      end else if (rn == 20) begin
        drain();
      end else if (rn == 30) begin
        no_idle = 1'b1;
        add_frame(16'h0123);
        random_sent += bytes_q.size();
        send_region(1'b1, -1);
      end
      no_idle = ($urandom_range(0, 6) == 0);
      send_random_region();
      rn++;
    end
    no_idle = 1'b0;
    drain();

    $display("Checked %0d region statuses over %0d bytes: clean, bad head, bad tail,",
             sb.regions, sb.bytes_seen);
    $display("truncated and restarted regions, a long two-byte-length frame and backpressure.");
    if (sb.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Timed out with %0d statuses outstanding", sb.pending());
    $display("Some tests failed");
    $finish;
  end

endmodule

[filelist.f]
src/ofv_pkg.sv
src/ofv_frame_check.sv
src/order_frame_validator.sv
tb/sv/order_frame_validator_tb.sv
